// ----- src/sfilt_pkg.sv -----
// ---------------------------------------------------------------------------
// sfilt_pkg: shared types and constants of the separable 8-tap 2-D filter
// Widths, arithmetic constants, register indexes and the cell control word.
// ---------------------------------------------------------------------------
package sfilt_pkg;

   // geometry
   localparam int MAX_WIDTH        = 128;
   localparam int MAX_HEIGHT       = 128;
   localparam int TAP_COUNT        = 8;
   localparam int HIST_ROWS        = TAP_COUNT - 1;
   localparam int FRACTION_BITS    = 7;
   localparam int FIRST_ROUND_BITS = 3;
   localparam int PIXEL_MAX        = 255;

   // arithmetic constants
   localparam int ROUND1      = 2 * FRACTION_BITS - FIRST_ROUND_BITS;
   localparam int OFFSET_BITS = 8 + 2 * FRACTION_BITS - FIRST_ROUND_BITS;
   localparam int H_BIAS      = (1 << (8 + FRACTION_BITS - 1)) + (1 << (FIRST_ROUND_BITS - 1));
   localparam int V_BIAS      = (1 << OFFSET_BITS) + (1 << (ROUND1 - 1));
   localparam int POST_SUB    = (1 << (OFFSET_BITS - ROUND1)) +
                                (1 << (OFFSET_BITS - ROUND1 - 1));

   // widths
   localparam int PIX_W   = 8;
   localparam int TAP_W   = 8;
   localparam int MID_W   = 16;
   localparam int HPROD_W = TAP_W + PIX_W + 1;
   localparam int VPROD_W = TAP_W + MID_W;
   localparam int HSUM_W  = HPROD_W + 4;
   localparam int VSUM_W  = VPROD_W + 4;
   localparam int DIM_W   = 9;
   localparam int ADDR_W  = $clog2(MAX_WIDTH);
   localparam int COL_W   = $clog2(MAX_WIDTH + HIST_ROWS + 1);
   localparam int ROW_W   = $clog2(MAX_HEIGHT + HIST_ROWS + 1);
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_WIDTH     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_HEIGHT    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HORIZ_TAPS_LOW  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HORIZ_TAPS_HIGH = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_VERT_TAPS_LOW   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_VERT_TAPS_HIGH  = 3'd5;

   // Gaussian kernel {0, 8, 30, 52, 30, 8, 0, 0}, tap 0 in the low byte
   localparam logic [CSR_DATA_W-1:0] TAPS_LOW_RESET  = 32'h341E_0800;
   localparam logic [CSR_DATA_W-1:0] TAPS_HIGH_RESET = 32'h0000_081E;

   typedef logic        [PIX_W-1:0]   pix_type;
   typedef logic signed [TAP_W-1:0]   tap_type;
   typedef logic signed [MID_W-1:0]   mid_type;
   typedef logic signed [HPROD_W-1:0] hprod_type;
   typedef logic signed [VPROD_W-1:0] vprod_type;
   typedef logic signed [HSUM_W-1:0]  hsum_type;
   typedef logic signed [VSUM_W-1:0]  vsum_type;
   typedef logic        [ADDR_W-1:0]  addr_type;

   // control word broadcast along the cell row
   typedef struct packed {
      logic     shift;
      logic     rd;
      logic     wr;
      addr_type addr;
   } cell_ctrl_type;

endpackage

// ----- src/sfilt_ram.sv -----
// ---------------------------------------------------------------------------
// sfilt_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
module sfilt_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/sfilt_cell.sv -----
// ---------------------------------------------------------------------------
// sfilt_cell: one tap cell of the filter row
// Holds one pixel of the horizontal window and one delayed intermediate
// line; passes both to its left neighbor and forms the two tap products.
// ---------------------------------------------------------------------------
module sfilt_cell (
   input  logic                     clock,
   input  logic                     reset,
   input  sfilt_pkg::cell_ctrl_type ctrl,
   input  sfilt_pkg::pix_type       pix_from_right,
   output sfilt_pkg::pix_type       pix_out,
   input  sfilt_pkg::tap_type       h_tap,
   input  sfilt_pkg::tap_type       v_tap,
   input  sfilt_pkg::mid_type       line_from_right,
   output sfilt_pkg::mid_type       line_out,
   output sfilt_pkg::hprod_type     h_prod,
   output sfilt_pkg::vprod_type     v_prod
);
   import sfilt_pkg::*;

   pix_type   pix_ff, pix_in;
   hprod_type h_prod_ff, h_prod_in;
   vprod_type v_prod_ff, v_prod_in;
   logic [MID_W-1:0] line_rd;

   // pixel window tap: shifts one place left per accepted word
   assign pix_in = ctrl.shift ? pix_from_right : pix_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pix_ff <= '0;
      end else begin
         pix_ff <= pix_in;
      end
   end

   // line delay: one row of intermediates, refilled from the right neighbor
   sfilt_ram #(
      .WIDTH (MID_W),
      .DEPTH (MAX_WIDTH)
   ) u_line (
      .clock   (clock),
      .wr_en   (ctrl.wr),
      .wr_addr (ctrl.addr),
      .wr_data (line_from_right),
      .rd_en   (ctrl.rd),
      .rd_addr (ctrl.addr),
      .rd_data (line_rd)
   );

   // tap products, registered every cycle
   assign h_prod_in = hprod_type'(h_tap) * hprod_type'($signed({1'b0, pix_ff}));
   assign v_prod_in = vprod_type'(v_tap) * vprod_type'($signed(line_rd));

   always_ff @(posedge clock) begin
      h_prod_ff <= h_prod_in;
      v_prod_ff <= v_prod_in;
   end

   assign pix_out  = pix_ff;
   assign line_out = $signed(line_rd);
   assign h_prod   = h_prod_ff;
   assign v_prod   = v_prod_ff;

endmodule

// ----- src/separable_8tap_2d_filter.sv -----
// ---------------------------------------------------------------------------
// separable_8tap_2d_filter: streaming separable 8-tap 2-D pixel filter
// Horizontal 8-tap pass into a seven-line store, vertical 8-tap pass out.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/req_stall | req_in_pixel
//   rsp     | out       | rsp_valid/rsp_stall | rsp_out_pixel, rsp_block_end
//   csr     | in        | csr_write_enable    | csr_index, csr_write_data
//
// A word in a column that feeds the filter passes after acceptance through
// S_HMUL (product), S_HSUM (horizontal sum), S_VMUL (line store access) and
// S_VSUM (vertical sum) when it yields an output pixel, and ends after S_VMUL
// when it only fills the line store. Edge-padding words leave the sequencer idle.
// A result waiting on rsp_stall does not block acceptance of the next word;
// the vertical sum step holds until the output register is free.
// Synchronous reset restores the default size and Gaussian taps.
// ---------------------------------------------------------------------------
module separable_8tap_2d_filter (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [sfilt_pkg::PIX_W-1:0]         req_in_pixel,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [sfilt_pkg::PIX_W-1:0]         rsp_out_pixel,
   output logic                                rsp_block_end,
   input  logic                                csr_write_enable,
   input  logic [sfilt_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [sfilt_pkg::CSR_DATA_W-1:0]    csr_write_data
);
   import sfilt_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_HMUL = 5'b00010,
      S_HSUM = 5'b00100,
      S_VMUL = 5'b01000,
      S_VSUM = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic [7:0]            block_width_ff, block_height_ff;
   logic [CSR_DATA_W-1:0] htaps_low_ff, htaps_high_ff, vtaps_low_ff, vtaps_high_ff;
   logic                  size_write;

   // window position
   logic [COL_W-1:0] col_ff, col_in, col_next, width_end;
   logic [ROW_W-1:0] row_ff, row_in, row_next, height_end;
   logic [DIM_W-1:0] eff_width, eff_height;
   logic             h_range, v_range, last_pos;

   // per-word context
   addr_type x_ff;
   logic     hact_ff, vact_ff, last_ff;
   pix_type  px_ff;
   mid_type  mid_ff, mid_in;

   // cell row
   tap_type       h_tap [TAP_COUNT];
   tap_type       v_tap [TAP_COUNT];
   pix_type       pix_chain  [HIST_ROWS+1];
   mid_type       line_chain [HIST_ROWS+1];
   hprod_type     h_prod [HIST_ROWS];
   vprod_type     v_prod [HIST_ROWS];
   hprod_type     h7_prod_ff;
   vprod_type     v7_prod_ff;
   cell_ctrl_type cell_ctrl;

   // sums and output
   hsum_type         h_sum, h_shift;
   vsum_type         v_sum, v_shift;
   logic [MID_W-1:0] v_pre;
   pix_type          out_pixel;
   logic             req_accept, out_load;
   logic             rsp_valid_ff, rsp_valid_in;
   pix_type          rsp_pixel_ff;
   logic             rsp_end_ff;

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign size_write = csr_write_enable &&
                       ((csr_index == CSR_BLOCK_WIDTH) || (csr_index == CSR_BLOCK_HEIGHT));

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         block_width_ff  <= 8'(MAX_WIDTH);
         block_height_ff <= 8'(MAX_HEIGHT);
         htaps_low_ff    <= TAPS_LOW_RESET;
         htaps_high_ff   <= TAPS_HIGH_RESET;
         vtaps_low_ff    <= TAPS_LOW_RESET;
         vtaps_high_ff   <= TAPS_HIGH_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_BLOCK_WIDTH:     block_width_ff  <= csr_write_data[7:0];
            CSR_BLOCK_HEIGHT:    block_height_ff <= csr_write_data[7:0];
            CSR_HORIZ_TAPS_LOW:  htaps_low_ff    <= csr_write_data;
            CSR_HORIZ_TAPS_HIGH: htaps_high_ff   <= csr_write_data;
            CSR_VERT_TAPS_LOW:   vtaps_low_ff    <= csr_write_data;
            CSR_VERT_TAPS_HIGH:  vtaps_high_ff   <= csr_write_data;
            default: ;
         endcase
      end
   end

   // unpack tap bytes
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         h_tap[k]     = htaps_low_ff[8*k +: 8];
         h_tap[k + 4] = htaps_high_ff[8*k +: 8];
         v_tap[k]     = vtaps_low_ff[8*k +: 8];
         v_tap[k + 4] = vtaps_high_ff[8*k +: 8];
      end
   end

   // effective block size: zero acts as one, clamp to the maximum
   always_comb begin
      if (block_width_ff == '0) begin
         eff_width = DIM_W'(1);
      end else if (DIM_W'(block_width_ff) > DIM_W'(MAX_WIDTH)) begin
         eff_width = DIM_W'(MAX_WIDTH);
      end else begin
         eff_width = DIM_W'(block_width_ff);
      end
      if (block_height_ff == '0) begin
         eff_height = DIM_W'(1);
      end else if (DIM_W'(block_height_ff) > DIM_W'(MAX_HEIGHT)) begin
         eff_height = DIM_W'(MAX_HEIGHT);
      end else begin
         eff_height = DIM_W'(block_height_ff);
      end
   end

   assign width_end  = COL_W'(eff_width) + COL_W'(HIST_ROWS);
   assign height_end = ROW_W'(eff_height) + ROW_W'(HIST_ROWS);
   assign h_range    = (col_ff >= COL_W'(HIST_ROWS)) && (col_ff < width_end);
   assign v_range    = (row_ff >= ROW_W'(HIST_ROWS)) && (row_ff < height_end);
   assign last_pos   = (col_ff == width_end - COL_W'(1)) &&
                       (row_ff == height_end - ROW_W'(1));
   assign col_next   = col_ff + COL_W'(1);
   assign row_next   = row_ff + ROW_W'(1);

   // window position counters; a size write starts a new block
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (size_write) begin
         col_in = '0;
         row_in = '0;
      end else if (req_accept) begin
         if (col_next >= width_end) begin
            col_in = '0;
            row_in = (row_next >= height_end) ? '0 : row_next;
         end else begin
            col_in = col_next;
         end
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (req_accept && h_range) state_in = S_HMUL;
         S_HMUL: state_in = S_HSUM;
         S_HSUM: state_in = S_VMUL;
         S_VMUL: state_in = vact_ff ? S_VSUM : S_IDLE;
         S_VSUM: if (out_load) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         col_ff   <= '0;
         row_ff   <= '0;
         px_ff    <= '0;
      end else begin
         state_ff <= state_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         if (req_accept) begin
            px_ff <= req_in_pixel;
         end
      end
   end

   // per-word context captured at acceptance
   always_ff @(posedge clock) begin
      if (reset) begin
         hact_ff <= 1'b0;
         vact_ff <= 1'b0;
         last_ff <= 1'b0;
      end else if (req_accept) begin
         hact_ff <= h_range;
         vact_ff <= v_range;
         last_ff <= last_pos;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         x_ff <= ADDR_W'(col_ff - COL_W'(HIST_ROWS));
      end
   end

   // cell row control
   assign cell_ctrl.shift = req_accept;
   assign cell_ctrl.rd    = (state_ff == S_HMUL);
   assign cell_ctrl.wr    = (state_ff == S_VMUL);
   assign cell_ctrl.addr  = x_ff;

   // newest pixel and newest intermediate enter at the right end
   assign pix_chain[HIST_ROWS]  = px_ff;
   assign line_chain[HIST_ROWS] = mid_ff;

   for (genvar k = 0; k < HIST_ROWS; k++) begin : g_cell
      sfilt_cell u_cell (
         .clock           (clock),
         .reset           (reset),
         .ctrl            (cell_ctrl),
         .pix_from_right  (pix_chain[k+1]),
         .pix_out         (pix_chain[k]),
         .h_tap           (h_tap[k]),
         .v_tap           (v_tap[k]),
         .line_from_right (line_chain[k+1]),
         .line_out        (line_chain[k]),
         .h_prod          (h_prod[k]),
         .v_prod          (v_prod[k])
      );
   end

   // last tap works on the newest pixel and the current intermediate
   always_ff @(posedge clock) begin
      h7_prod_ff <= hprod_type'(h_tap[TAP_COUNT-1]) * hprod_type'($signed({1'b0, px_ff}));
      v7_prod_ff <= vprod_type'(v_tap[TAP_COUNT-1]) * vprod_type'(mid_ff);
   end

   // horizontal sum, round and wrap to 16 bits
   always_comb begin
      h_sum = hsum_type'(H_BIAS) + hsum_type'(h7_prod_ff);
      for (int k = 0; k < HIST_ROWS; k++) begin
         h_sum = h_sum + hsum_type'(h_prod[k]);
      end
      h_shift = h_sum >>> FIRST_ROUND_BITS;
      mid_in  = h_shift[MID_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_HSUM) begin
         mid_ff <= mid_in;
      end
   end

   // vertical sum, round, remove offset, wrap and clip
   always_comb begin
      v_sum = vsum_type'(V_BIAS) + vsum_type'(v7_prod_ff);
      for (int k = 0; k < HIST_ROWS; k++) begin
         v_sum = v_sum + vsum_type'(v_prod[k]);
      end
      v_shift = v_sum >>> ROUND1;
      v_pre   = v_shift[MID_W-1:0] - MID_W'(POST_SUB);
      priority if (v_pre[MID_W-1]) begin
         out_pixel = '0;
      end else if (v_pre > MID_W'(PIXEL_MAX)) begin
         out_pixel = PIX_W'(PIXEL_MAX);
      end else begin
         out_pixel = v_pre[PIX_W-1:0];
      end
   end

   // output word register
   assign out_load     = (state_ff == S_VSUM) && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_pixel_ff <= out_pixel;
         rsp_end_ff   <= last_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_pixel = rsp_pixel_ff;
   assign rsp_block_end = rsp_end_ff;

   // checks
   a_vsum_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_VSUM && rsp_valid_ff && rsp_stall) |=> (state_ff == S_VSUM))
      else $error("vertical sum step left while output word stalled");

   a_active_start: assert property (@(posedge clock) disable iff (reset)
      (req_accept && h_range) |=> (state_ff == S_HMUL))
      else $error("active column word did not start the filter sequence");

   a_store_write: assert property (@(posedge clock) disable iff (reset)
      cell_ctrl.wr |-> hact_ff)
      else $error("line store written for a padding column");

   a_block_wrap: assert property (@(posedge clock) disable iff (reset)
      (out_load && last_ff) |-> (col_ff == '0 && row_ff == '0))
      else $error("block end word while position counters not wrapped");

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb: self-checking bench for separable_8tap_2d_filter
// Streams padded pixel windows through the filter and predicts every output
// pixel and block_end flag with an in-bench copy of the separable filter.
// A directed plan covers reset defaults, size clamping, tap extremes and
// wrap-around, mid-block size and tap writes, and unused register indexes.
// Random blocks with random sizes, kernels and content follow. Both sides
// idle in random bursts, except near the end of the run.
// ---------------------------------------------------------------------------
module tb;
   import sfilt_pkg::*;

   localparam int SETTLE_CYCLES = 8;
   localparam int IDLE_LIMIT    = 2000;
   localparam int RANDOM_WORDS  = 1050;
   localparam int CALM_WORDS    = 800;

   // indexes the register map leaves unused; writes there must be ignored
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = 3'd7;

   typedef enum {FILL_FLAT, FILL_NOISE, FILL_EXTREME} fill_kind_t;

   typedef struct {
      pix_type pixel;
      logic    last;
   } out_word_t;

   // one block of the directed plan
   typedef struct {
      logic [7:0]            wr_mask;   // bit i set: write register i
      logic [CSR_DATA_W-1:0] width;
      logic [CSR_DATA_W-1:0] height;
      logic [CSR_DATA_W-1:0] hlo;
      logic [CSR_DATA_W-1:0] hhi;
      logic [CSR_DATA_W-1:0] vlo;
      logic [CSR_DATA_W-1:0] vhi;
      fill_kind_t            fill;
      int                    level;     // pixel for flat fill
      int                    words;     // 0: rest of the block
      int                    flat_out;  // known output pixel, -1: predicted
   } plan_row_t;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [PIX_W-1:0]      req_in_pixel;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [PIX_W-1:0]      rsp_out_pixel;
   logic                  rsp_block_end;
   logic                  csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   // filter model state
   logic [7:0]            cfg_width;
   logic [7:0]            cfg_height;
   logic [CSR_DATA_W-1:0] htap_lo, htap_hi, vtap_lo, vtap_hi;
   pix_type               px_hist [HIST_ROWS];
   mid_type               line_mem [HIST_ROWS][MAX_WIDTH];
   int                    col_pos;
   int                    row_pos;

   out_word_t pending_pixels[$];
   int        miss_count;
   int        idle_run;
   int        gap_odds;
   int        stall_odds;
   int        rand_words;

   separable_8tap_2d_filter uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_in_pixel     (req_in_pixel),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_pixel    (rsp_out_pixel),
      .rsp_block_end    (rsp_block_end),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ---------------- filter model ----------------

   function automatic int clamp_size(logic [7:0] v, int top);
      if (v == 0) return 1;
      if (v > top) return top;
      return v;
   endfunction

   function automatic tap_type tap_at(logic [CSR_DATA_W-1:0] lo,
                                      logic [CSR_DATA_W-1:0] hi, int k);
      if (k < 4) return tap_type'(lo[8*k +: 8]);
      return tap_type'(hi[8*(k-4) +: 8]);
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pack_taps(int t0, int t1, int t2, int t3);
      return {t3[7:0], t2[7:0], t1[7:0], t0[7:0]};
   endfunction

   function automatic int block_words_left();
      int span;
      span = clamp_size(cfg_width, MAX_WIDTH) + HIST_ROWS;
      return (clamp_size(cfg_height, MAX_HEIGHT) + HIST_ROWS) * span
             - (row_pos * span + col_pos);
   endfunction

   function automatic void apply_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_BLOCK_WIDTH: begin
            cfg_width = data[7:0];
            col_pos = 0;
            row_pos = 0;
         end
         CSR_BLOCK_HEIGHT: begin
            cfg_height = data[7:0];
            col_pos = 0;
            row_pos = 0;
         end
         CSR_HORIZ_TAPS_LOW:  htap_lo = data;
         CSR_HORIZ_TAPS_HIGH: htap_hi = data;
         CSR_VERT_TAPS_LOW:   vtap_lo = data;
         CSR_VERT_TAPS_HIGH:  vtap_hi = data;
         default: ;
      endcase
   endfunction

   // one accepted pixel: horizontal pass, vertical pass, window advance
   function automatic void filter_word(pix_type px);
      int      ew, eh, x, slot;
      longint  acc, vacc, pre;
      mid_type mid, level;
      pix_type win [TAP_COUNT];
      out_word_t res;
      ew = clamp_size(cfg_width, MAX_WIDTH);
      eh = clamp_size(cfg_height, MAX_HEIGHT);
      for (int k = 0; k < HIST_ROWS; k++) win[k] = px_hist[k];
      win[TAP_COUNT-1] = px;
      if (col_pos >= HIST_ROWS && col_pos < ew + HIST_ROWS) begin
         x = col_pos - HIST_ROWS;
         acc = longint'(1) << (8 + FRACTION_BITS - 1);
         for (int k = 0; k < TAP_COUNT; k++)
            acc += longint'(tap_at(htap_lo, htap_hi, k)) * longint'(win[k]);
         acc = (acc + (longint'(1) << (FIRST_ROUND_BITS - 1))) >>> FIRST_ROUND_BITS;
         mid = acc[MID_W-1:0];
         if (row_pos >= HIST_ROWS && row_pos < eh + HIST_ROWS) begin
            vacc = longint'(1) << OFFSET_BITS;
            for (int k = 0; k < HIST_ROWS; k++) begin
               slot = (row_pos + k) % HIST_ROWS;
               vacc += longint'(tap_at(vtap_lo, vtap_hi, k)) * longint'(line_mem[slot][x]);
            end
            vacc += longint'(tap_at(vtap_lo, vtap_hi, TAP_COUNT - 1)) * longint'(mid);
            pre = ((vacc + (longint'(1) << (ROUND1 - 1))) >>> ROUND1)
                  - ((longint'(1) << (OFFSET_BITS - ROUND1))
                     + (longint'(1) << (OFFSET_BITS - ROUND1 - 1)));
            level = pre[MID_W-1:0];
            if (level < 0) res.pixel = '0;
            else if (level > PIXEL_MAX) res.pixel = PIXEL_MAX;
            else res.pixel = level[PIX_W-1:0];
            res.last = (col_pos == ew + HIST_ROWS - 1) && (row_pos == eh + HIST_ROWS - 1);
            pending_pixels.push_back(res);
         end
         line_mem[row_pos % HIST_ROWS][x] = mid;
      end
      for (int k = 0; k + 1 < HIST_ROWS; k++) px_hist[k] = px_hist[k+1];
      px_hist[HIST_ROWS-1] = px;
      col_pos++;
      if (col_pos >= ew + HIST_ROWS) begin
         col_pos = 0;
         row_pos++;
         if (row_pos >= eh + HIST_ROWS) row_pos = 0;
      end
   endfunction

   // ---------------- drivers ----------------

   // caller lowers csr_write_enable after the last write of a group
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      apply_reg(idx, data);
   endtask

   task automatic send_pixel(pix_type p);
      if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_in_pixel <= p;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic stream_words(int count, fill_kind_t fill, int level, int flat_out);
      pix_type   p;
      int        depth;
      out_word_t w;
      for (int i = 0; i < count; i++) begin
         case (fill)
            FILL_FLAT:    p = level[PIX_W-1:0];
            FILL_EXTREME: p = $urandom_range(0, 1) ? pix_type'(PIXEL_MAX) : '0;
            default:      p = $urandom_range(0, PIXEL_MAX);
         endcase
         send_pixel(p);
         depth = pending_pixels.size();
         filter_word(p);
         // flat content through a unity-gain kernel comes out unchanged
         if (flat_out >= 0 && pending_pixels.size() > depth) begin
            w = pending_pixels.pop_back();
            w.pixel = flat_out[PIX_W-1:0];
            pending_pixels.push_back(w);
         end
      end
      req_valid <= 1'b0;
   endtask

   // block idle: nothing owed, pipeline flushed of padding words
   task automatic drain();
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_plan_row(plan_row_t r);
      drain();
      if (r.wr_mask[CSR_BLOCK_WIDTH])     write_reg(CSR_BLOCK_WIDTH, r.width);
      if (r.wr_mask[CSR_BLOCK_HEIGHT])    write_reg(CSR_BLOCK_HEIGHT, r.height);
      if (r.wr_mask[CSR_HORIZ_TAPS_LOW])  write_reg(CSR_HORIZ_TAPS_LOW, r.hlo);
      if (r.wr_mask[CSR_HORIZ_TAPS_HIGH]) write_reg(CSR_HORIZ_TAPS_HIGH, r.hhi);
      if (r.wr_mask[CSR_VERT_TAPS_LOW])   write_reg(CSR_VERT_TAPS_LOW, r.vlo);
      if (r.wr_mask[CSR_VERT_TAPS_HIGH])  write_reg(CSR_VERT_TAPS_HIGH, r.vhi);
      if (r.wr_mask[CSR_SPARE_A])         write_reg(CSR_SPARE_A, $urandom());
      if (r.wr_mask[CSR_SPARE_B])         write_reg(CSR_SPARE_B, $urandom());
      csr_write_enable <= 1'b0;
      stream_words(r.words == 0 ? block_words_left() : r.words, r.fill, r.level, r.flat_out);
   endtask

   // kernel choice: default, raw random bits, or random unity-gain
   function automatic void pick_taps(output logic [CSR_DATA_W-1:0] lo,
                                     output logic [CSR_DATA_W-1:0] hi);
      int t [TAP_COUNT];
      int sum;
      lo = TAPS_LOW_RESET;
      hi = TAPS_HIGH_RESET;
      case ($urandom_range(0, 3))
         0: ;
         1: begin
            lo = $urandom();
            hi = $urandom();
         end
         default: begin
            sum = 0;
            for (int k = 0; k < TAP_COUNT; k++) begin
               t[k] = $urandom_range(0, 40);
               t[k] = t[k] - 10;
               if (k != 3) sum += t[k];
            end
            t[3] = 128 - sum;
            if (t[3] <= 127) begin
               lo = pack_taps(t[0], t[1], t[2], t[3]);
               hi = pack_taps(t[4], t[5], t[6], t[7]);
            end
         end
      endcase
   endfunction

   task automatic random_phase();
      int                    w, h, words, left, pick;
      logic [CSR_DATA_W-1:0] lo, hi;
      fill_kind_t            fill;
      drain();
      if (rand_words >= CALM_WORDS) begin
         gap_odds = 0;
         stall_odds = 0;
      end else begin
         pick = $urandom_range(0, 3);
         gap_odds = (pick == 0) ? 0 : (pick == 1) ? 3 : 10;
         pick = $urandom_range(0, 3);
         stall_odds = (pick == 0) ? 0 : (pick == 1) ? 3 : 10;
      end
      // mostly a fresh small block; sometimes only new taps mid-block
      if ($urandom_range(0, 3) != 0) begin
         w = ($urandom_range(0, 15) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
         h = $urandom_range(0, 8);
         write_reg(CSR_BLOCK_WIDTH, ($urandom() & 32'hFFFF_FF00) | w);
         write_reg(CSR_BLOCK_HEIGHT, ($urandom() & 32'hFFFF_FF00) | h);
      end
      if ($urandom_range(0, 2) != 0) begin
         pick_taps(lo, hi);
         write_reg(CSR_HORIZ_TAPS_LOW, lo);
         write_reg(CSR_HORIZ_TAPS_HIGH, hi);
      end
      if ($urandom_range(0, 2) != 0) begin
         pick_taps(lo, hi);
         write_reg(CSR_VERT_TAPS_LOW, lo);
         write_reg(CSR_VERT_TAPS_HIGH, hi);
      end
      csr_write_enable <= 1'b0;
      left = block_words_left();
      pick = $urandom_range(0, 9);
      if (pick < 2) words = $urandom_range(1, left);
      else if (pick == 2) words = left + block_words_left() - left
                                  + (clamp_size(cfg_height, MAX_HEIGHT) + HIST_ROWS)
                                  * (clamp_size(cfg_width, MAX_WIDTH) + HIST_ROWS);
      else words = left;
      pick = $urandom_range(0, 9);
      fill = (pick == 0) ? FILL_FLAT : (pick < 3) ? FILL_EXTREME : FILL_NOISE;
      stream_words(words, fill, $urandom_range(0, PIXEL_MAX), -1);
      rand_words += words;
   endtask

   // ---------------- output side ----------------

   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 15)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   function automatic void report_miss(string what, int want, int got);
      miss_count++;
      if (miss_count <= 10)
         $display("mismatch %s: expected %0d, got %0d at %0t", what, want, got, $realtime);
   endfunction

   // compare every accepted output word with the oldest prediction
   always @(posedge clock) begin : check_out
      out_word_t want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_pixels.size() == 0) begin
            report_miss("unexpected output word, pixel", -1, rsp_out_pixel);
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_out_pixel !== want.pixel)
               report_miss("out_pixel", want.pixel, rsp_out_pixel);
            if (rsp_block_end !== want.last)
               report_miss("block_end", want.last, rsp_block_end);
         end
      end
   end

   // watchdog on cycles without any accepted word
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         idle_run <= 0;
      else
         idle_run <= idle_run + 1;
      if (idle_run >= IDLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // ---------------- main sequence ----------------

   initial begin : stimulus
      plan_row_t plan [13];
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_in_pixel     = '0;
      csr_write_enable = 1'b0;
      csr_index        = CSR_BLOCK_WIDTH;
      csr_write_data   = '0;
      miss_count       = 0;
      idle_run         = 0;
      rand_words       = 0;
      gap_odds         = 8;
      stall_odds       = 8;
      cfg_width        = MAX_WIDTH;
      cfg_height       = MAX_HEIGHT;
      htap_lo          = TAPS_LOW_RESET;
      htap_hi          = TAPS_HIGH_RESET;
      vtap_lo          = TAPS_LOW_RESET;
      vtap_hi          = TAPS_HIGH_RESET;
      col_pos          = 0;
      row_pos          = 0;
      for (int k = 0; k < HIST_ROWS; k++) px_hist[k] = '0;

      // reset width and kernel, one output row of full width
      plan[0]  = '{8'h02, 0, 1, 0, 0, 0, 0, FILL_FLAT, 255, 0, 255};
      // width above range acts as full width, height zero as one
      plan[1]  = '{8'h03, 255, 0, 0, 0, 0, 0, FILL_FLAT, 0, 0, 0};
      // width zero acts as one, height above range as full height
      plan[2]  = '{8'h03, 0, 200, 0, 0, 0, 0, FILL_FLAT, 200, 0, 200};
      plan[3]  = '{8'h3F, 3, 2, TAPS_LOW_RESET, TAPS_HIGH_RESET,
                   TAPS_LOW_RESET, TAPS_HIGH_RESET, FILL_NOISE, 0, 0, -1};
      // largest positive taps: intermediate wraps past 16 bits
      plan[4]  = '{8'h3F, 4, 3, 32'h7F7F_7F7F, 32'h7F7F_7F7F,
                   32'h7F7F_7F7F, 32'h7F7F_7F7F, FILL_EXTREME, 0, 0, -1};
      // most negative taps: rounding of negative sums
      plan[5]  = '{8'h3F, 2, 2, 32'h8080_8080, 32'h8080_8080,
                   32'h8080_8080, 32'h8080_8080, FILL_FLAT, 255, 0, -1};
      plan[6]  = '{8'h3F, 6, 2, 32'h4000_0000, 32'h0000_0040,
                   TAPS_LOW_RESET, TAPS_HIGH_RESET, FILL_NOISE, 0, 0, -1};
      plan[7]  = '{8'h3F, 5, 3, 32'hFF05_F001, 32'h3A7F_C210,
                   32'h10F8_207F, 32'h81EC_3002, FILL_NOISE, 0, 0, -1};
      // abandon a block partway through its output rows
      plan[8]  = '{8'h3F, 3, 3, TAPS_LOW_RESET, TAPS_HIGH_RESET,
                   TAPS_LOW_RESET, TAPS_HIGH_RESET, FILL_NOISE, 0, 85, -1};
      // size write restarts the window
      plan[9]  = '{8'h03, 2, 1, 0, 0, 0, 0, FILL_EXTREME, 0, 0, -1};
      // unused indexes must leave the kernel alone
      plan[10] = '{8'hFC, 0, 0, TAPS_LOW_RESET, TAPS_HIGH_RESET,
                   TAPS_LOW_RESET, TAPS_HIGH_RESET, FILL_FLAT, 77, 0, 77};
      // new taps in the middle of a block take effect at once
      plan[11] = '{8'h03, 4, 4, 0, 0, 0, 0, FILL_NOISE, 0, 60, -1};
      plan[12] = '{8'h3C, 0, 0, 32'h0C1A_F4E8, 32'h02FD_2B11,
                   32'h2A05_F9FE, 32'h0314_1E02, FILL_NOISE, 0, 0, -1};

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < 13; i++) run_plan_row(plan[i]);
      while (rand_words < RANDOM_WORDS) random_phase();

      drain();
      if (miss_count == 0 && pending_pixels.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

// ----- sim.f -----
src/sfilt_pkg.sv
src/sfilt_ram.sv
src/sfilt_cell.sv
src/separable_8tap_2d_filter.sv
verif/tb.sv
